@@ hw/rtl/fpba_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fpba_pkg
// Shared constants, codes and types of the fit policy block allocator.
// ----------------------------------------------------------------------------
package fpba_pkg;

	localparam int MAX_BLOCKS = 16;
	localparam int SIZE_BITS  = 16;
	localparam int IDX_W      = $clog2(MAX_BLOCKS);
	localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
	localparam int OUT_IDX_W  = 4;

	typedef enum logic [1:0] {
		CMD_LOAD    = 2'd0,
		CMD_ALLOC   = 2'd1,
		CMD_RESTART = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		FIT_FIRST = 2'd0,
		FIT_BEST  = 2'd1,
		FIT_WORST = 2'd2
	} fit_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_NOFIT = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_RESULT
	} state_t;

	typedef struct packed {
		status_t                status;
		logic [OUT_IDX_W-1:0]   index;
		logic [SIZE_BITS-1:0]   size;
		logic [SIZE_BITS-1:0]   leftover;
	} res_t;

endpackage : fpba_pkg
`default_nettype wire

@@ hw/rtl/fpba_size_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fpba_size_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fpba_size_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule : fpba_size_ram
`default_nettype wire

@@ hw/rtl/fpba_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fpba_ctrl
// Command sequencer: loads sizes into the size RAM, scans it for allocates
// and keeps the used marks and the fill count.
// ----------------------------------------------------------------------------
module fpba_ctrl (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [1:0]                  fit_mode,
	input  wire logic                        in_valid,
	output      logic                        in_ready,
	input  wire logic [1:0]                  cmd,
	input  wire logic [fpba_pkg::SIZE_BITS-1:0] block_size_in,
	input  wire logic [fpba_pkg::SIZE_BITS-1:0] request_size,
	output      logic                        res_valid,
	input  wire logic                        res_ready,
	output      fpba_pkg::res_t              res
);
	import fpba_pkg::*;

	state_t               state_q, state_nxt;
	logic [CNT_W-1:0]     cnt_q;
	logic [CNT_W-1:0]     issue_q;
	logic [MAX_BLOCKS-1:0] used_q;
	logic                 found_q;
	logic                 mark_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic [SIZE_BITS-1:0] best_size_q;
	logic [IDX_W-1:0]     chk_idx_s1;
	logic [SIZE_BITS-1:0] req_q;
	res_t                 res_q;

	logic                 accept;
	logic                 full;
	logic                 scan_last;
	logic                 fits;
	logic                 take;
	logic                 nb_found;
	logic [IDX_W-1:0]     nb_idx;
	logic [SIZE_BITS-1:0] nb_size;

	logic                 ram_we;
	logic [IDX_W-1:0]     ram_waddr;
	logic                 ram_re;
	logic [IDX_W-1:0]     ram_raddr;
	logic [SIZE_BITS-1:0] ram_rdata;

	fpba_size_ram #(
		.DEPTH(MAX_BLOCKS),
		.WIDTH(SIZE_BITS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(block_size_in),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign accept    = in_valid && (state_q == S_IDLE);
	assign full      = (cnt_q == CNT_W'(MAX_BLOCKS));
	assign scan_last = (issue_q == cnt_q);

	// Candidate check on the entry whose size arrives this cycle.
	always_comb begin
		fits = !used_q[chk_idx_s1] && (ram_rdata >= req_q);
		take = fits && (!found_q
			|| ((fit_mode == FIT_BEST) && (ram_rdata < best_size_q))
			|| ((fit_mode == FIT_WORST) && (ram_rdata > best_size_q)));
		nb_found = found_q || take;
		nb_idx   = take ? chk_idx_s1 : best_idx_q;
		nb_size  = take ? ram_rdata : best_size_q;
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if ((cmd == CMD_ALLOC) && (cnt_q != '0)) begin
						state_nxt = S_SCAN;
					end else begin
						state_nxt = S_RESULT;
					end
				end
			end
			S_SCAN: begin
				if (scan_last) begin
					state_nxt = S_RESULT;
				end
			end
			S_RESULT: begin
				if (res_ready) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		res_valid = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = cnt_q[IDX_W-1:0];
		ram_re    = 1'b0;
		ram_raddr = issue_q[IDX_W-1:0];
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && (cmd == CMD_LOAD) && !full) begin
					ram_we = 1'b1;
				end
				if (in_valid && (cmd == CMD_ALLOC)) begin
					ram_re    = 1'b1;
					ram_raddr = '0;
				end
			end
			S_SCAN: begin
				ram_re = !scan_last;
			end
			S_RESULT: begin
				res_valid = 1'b1;
			end
			default: ;
		endcase
	end

	assign res = res_q;

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			used_q  <= '0;
			found_q <= 1'b0;
			mark_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				found_q <= 1'b0;
				mark_q  <= 1'b0;
				priority case (1'b1)
					(cmd == CMD_LOAD): begin
						if (!full) begin
							used_q[cnt_q[IDX_W-1:0]] <= 1'b0;
							cnt_q <= cnt_q + CNT_W'(1);
						end
					end
					(cmd == CMD_RESTART): used_q <= '0;
					default: ;
				endcase
			end
			if (state_q == S_SCAN) begin
				found_q <= nb_found;
				if (scan_last) begin
					mark_q <= nb_found;
				end
			end
			if ((state_q == S_RESULT) && res_ready && mark_q) begin
				used_q[best_idx_q] <= 1'b1;
				mark_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q      <= request_size;
			issue_q    <= CNT_W'(1);
			chk_idx_s1 <= '0;
			if ((cmd == CMD_LOAD) && full) begin
				res_q <= '{status: STAT_FULL, index: '0, size: '0, leftover: '0};
			end else if (cmd == CMD_LOAD) begin
				res_q <= '{status: STAT_OK, index: OUT_IDX_W'(cnt_q[IDX_W-1:0]),
					size: block_size_in, leftover: '0};
			end else if (cmd == CMD_ALLOC) begin
				res_q <= '{status: STAT_NOFIT, index: '0, size: '0, leftover: '0};
			end else begin
				res_q <= '{status: STAT_OK, index: '0, size: '0, leftover: '0};
			end
		end
		if (state_q == S_SCAN) begin
			best_idx_q  <= nb_idx;
			best_size_q <= nb_size;
			if (!scan_last) begin
				issue_q    <= issue_q + CNT_W'(1);
				chk_idx_s1 <= issue_q[IDX_W-1:0];
			end else if (nb_found) begin
				res_q <= '{status: STAT_OK, index: OUT_IDX_W'(nb_idx), size: nb_size,
					leftover: nb_size - req_q};
			end
		end
	end

endmodule : fpba_ctrl
`default_nettype wire

@@ hw/rtl/fit_policy_block_allocator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fit_policy_block_allocator
// Fixed-partition block allocator with first, best or worst fit placement.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+---------------------------------------
//  input    | in_valid / in_ready  | cmd, block_size_in, request_size
//  output   | out_valid / out_ready| status, block_index, granted_size,
//           |                      | leftover
//  config   | cfg_we (no wait)     | cfg_wdata = fit_mode
//
// A load, restart, unknown command or allocate on an empty table goes from
// acceptance straight to the result state and from there into the output
// register, which raises out_valid. An allocate first scans the loaded blocks:
// the size RAM has one read port and is read one entry per cycle, each entry
// compared against the best candidate so far. The sequencer takes its next
// item in the cycle after its result moves to the output register.
// One item is processed at a time. The output register frees the sequencer,
// so the next item is accepted while a result still waits for out_ready.
// Reset clears the fill count, the used marks and the mode; the size RAM
// needs no clearing because only loaded entries are ever compared.
//
module fit_policy_block_allocator (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [1:0]                     cfg_wdata,
	input  wire logic                           in_valid,
	output      logic                           in_ready,
	input  wire logic [1:0]                     cmd,
	input  wire logic [fpba_pkg::SIZE_BITS-1:0] block_size_in,
	input  wire logic [fpba_pkg::SIZE_BITS-1:0] request_size,
	output      logic                           out_valid,
	input  wire logic                           out_ready,
	output      logic [1:0]                     status,
	output      logic [fpba_pkg::OUT_IDX_W-1:0] block_index,
	output      logic [fpba_pkg::SIZE_BITS-1:0] granted_size,
	output      logic [fpba_pkg::SIZE_BITS-1:0] leftover
);
	import fpba_pkg::*;

	logic [1:0] fit_mode_q;
	logic       res_valid;
	logic       res_ready;
	res_t       res;
	logic       out_valid_q;
	res_t       out_res_q;

	// The mode register. It is to be written only while the block is idle; the block
	// itself does not enforce this, so the sequencer reads it directly during a scan.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q <= FIT_FIRST;
		end else if (cfg_we) begin
			fit_mode_q <= cfg_wdata;
		end
	end

	fpba_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.fit_mode     (fit_mode_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.block_size_in(block_size_in),
		.request_size (request_size),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res)
	);

	// Output register: it takes a new result whenever it is empty or its
	// current item is being taken in the same cycle.
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_res_q.status;
	assign block_index  = out_res_q.index;
	assign granted_size = out_res_q.size;
	assign leftover     = out_res_q.leftover;

endmodule : fit_policy_block_allocator
`default_nettype wire

@@ hw/rtl/fpba_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fpba_checker
// Port-level checks of the fit policy block allocator, bound to the top.
// ----------------------------------------------------------------------------
module fpba_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           in_valid,
	input wire logic                           in_ready,
	input wire logic                           out_valid,
	input wire logic                           out_ready,
	input wire logic [1:0]                     status,
	input wire logic [fpba_pkg::OUT_IDX_W-1:0] block_index,
	input wire logic [fpba_pkg::SIZE_BITS-1:0] granted_size,
	input wire logic [fpba_pkg::SIZE_BITS-1:0] leftover
);
	import fpba_pkg::*;

	// Only one item is in the sequencer at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted while an item is still in work");

	// A failed load or allocate reports all payload fields as zero.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == STAT_NOFIT || status == STAT_FULL)) |->
		(block_index == '0 && granted_size == '0 && leftover == '0))
		else $error("failure result carries nonzero fields");

	// The fragment never exceeds the granted block.
	a_leftover: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (leftover <= granted_size))
		else $error("leftover larger than granted size");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
		(out_valid && $stable(status) && $stable(block_index)
			&& $stable(granted_size) && $stable(leftover)))
		else $error("result changed while stalled");

endmodule : fpba_checker

bind fit_policy_block_allocator fpba_checker u_fpba_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.status      (status),
	.block_index (block_index),
	.granted_size(granted_size),
	.leftover    (leftover)
);
`default_nettype wire
